// ===== hdl/sep_pkg.sv =====
package sep_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int PEAK_W      = 16;
  localparam int CHUNK_LEN_W = 12;
  localparam int THR_W       = 15;
  localparam int CNT_W       = 16;
  localparam int CAUSE_W     = 2;
  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 32;
  localparam int REG_IDX_W   = 3;

  // Register indexes (byte address is four times the index).
  localparam logic [REG_IDX_W-1:0] REG_CHUNK_LENGTH     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SPEECH_THRESHOLD = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_MAX_CHUNKS       = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SILENCE_CHUNKS   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_NO_SPEECH_CHUNKS = 3'd4;

  localparam logic [CHUNK_LEN_W-1:0] CHUNK_LENGTH_RST     = 12'd800;
  localparam logic [THR_W-1:0]       SPEECH_THRESHOLD_RST = 15'd600;
  localparam logic [CNT_W-1:0]       MAX_CHUNKS_RST       = 16'd200;
  localparam logic [CNT_W-1:0]       SILENCE_CHUNKS_RST   = 16'd20;
  localparam logic [CNT_W-1:0]       NO_SPEECH_CHUNKS_RST = 16'd100;

  localparam logic [CAUSE_W-1:0] CAUSE_NONE      = 2'd0;
  localparam logic [CAUSE_W-1:0] CAUSE_MAX_LEN   = 2'd1;
  localparam logic [CAUSE_W-1:0] CAUSE_SILENCE   = 2'd2;
  localparam logic [CAUSE_W-1:0] CAUSE_NO_SPEECH = 2'd3;

  typedef struct packed {
    logic [CHUNK_LEN_W-1:0] chunk_length;
    logic [THR_W-1:0]       speech_threshold;
    logic [CNT_W-1:0]       max_chunks;
    logic [CNT_W-1:0]       silence_chunks;
    logic [CNT_W-1:0]       no_speech_chunks;
  } sep_cfg_t;

  typedef struct packed {
    logic [PEAK_W-1:0]  chunk_peak;
    logic               heard_speech;
    logic               stop;
    logic [CAUSE_W-1:0] stop_cause;
  } sep_res_t;

endpackage

// ===== hdl/sep_if.sv =====
interface sep_in_if import sep_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       first;

  modport source (output valid, output sample, output first, input ready);
  modport sink (input valid, input sample, input first, output ready);
endinterface

interface sep_out_if import sep_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PEAK_W-1:0]  chunk_peak;
  logic               heard_speech;
  logic               stop;
  logic [CAUSE_W-1:0] stop_cause;

  modport source (output valid, output chunk_peak, output heard_speech, output stop,
                  output stop_cause, input ready);
  modport sink (input valid, input chunk_peak, input heard_speech, input stop,
                input stop_cause, output ready);
endinterface

// ===== hdl/sep_regs.sv =====
module sep_regs import sep_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output sep_cfg_t          cfg
);

  sep_cfg_t             cfg_r;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[ADDR_W-1:2];
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.chunk_length     <= CHUNK_LENGTH_RST;
      cfg_r.speech_threshold <= SPEECH_THRESHOLD_RST;
      cfg_r.max_chunks       <= MAX_CHUNKS_RST;
      cfg_r.silence_chunks   <= SILENCE_CHUNKS_RST;
      cfg_r.no_speech_chunks <= NO_SPEECH_CHUNKS_RST;
    end else if (wr_en) begin
      case (idx)
        REG_CHUNK_LENGTH:     cfg_r.chunk_length     <= pwdata[CHUNK_LEN_W-1:0];
        REG_SPEECH_THRESHOLD: cfg_r.speech_threshold <= pwdata[THR_W-1:0];
        REG_MAX_CHUNKS:       cfg_r.max_chunks       <= pwdata[CNT_W-1:0];
        REG_SILENCE_CHUNKS:   cfg_r.silence_chunks   <= pwdata[CNT_W-1:0];
        REG_NO_SPEECH_CHUNKS: cfg_r.no_speech_chunks <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_CHUNK_LENGTH:     prdata = DATA_W'(cfg_r.chunk_length);
      REG_SPEECH_THRESHOLD: prdata = DATA_W'(cfg_r.speech_threshold);
      REG_MAX_CHUNKS:       prdata = DATA_W'(cfg_r.max_chunks);
      REG_SILENCE_CHUNKS:   prdata = DATA_W'(cfg_r.silence_chunks);
      REG_NO_SPEECH_CHUNKS: prdata = DATA_W'(cfg_r.no_speech_chunks);
      default:              prdata = '0;
    endcase
  end

endmodule

// ===== hdl/sep_core.sv =====
module sep_core import sep_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       fire,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       first,
  input  sep_cfg_t                   cfg,
  output logic                       res_valid,
  output sep_res_t                   res
);

  logic [CHUNK_LEN_W-1:0] sample_count_r, sample_count_nxt;
  logic [PEAK_W-1:0]      running_peak_r, running_peak_nxt;
  logic [CNT_W-1:0]       elapsed_r, elapsed_nxt;
  logic [CNT_W-1:0]       last_speech_r, last_speech_nxt;
  logic                   seen_r, seen_nxt;
  logic                   stopped_r, stopped_nxt;

  // Session state after an optional clear by the first flag.
  logic [CHUNK_LEN_W-1:0] sc_c;
  logic [PEAK_W-1:0]      pk_c;
  logic [CNT_W-1:0]       el_c, last_c;
  logic                   seen_c, stopped_c;

  logic [PEAK_W-1:0]      mag, pk;
  logic [CHUNK_LEN_W:0]   count;
  logic                   chunk_end, active, speech;
  logic [CNT_W-1:0]       el_n, last_n, gap;
  logic                   seen_n;
  logic [CAUSE_W-1:0]     cause;

  always_comb begin
    sc_c      = first ? '0 : sample_count_r;
    pk_c      = first ? '0 : running_peak_r;
    el_c      = first ? '0 : elapsed_r;
    last_c    = first ? '0 : last_speech_r;
    seen_c    = first ? 1'b0 : seen_r;
    stopped_c = first ? 1'b0 : stopped_r;
    active    = !stopped_c;

    // The most negative sample negates to 0x8000, which is its true magnitude.
    mag = sample[SAMPLE_W-1] ? PEAK_W'(-sample) : PEAK_W'(sample);
    pk  = (mag > pk_c) ? mag : pk_c;

    count     = {1'b0, sc_c} + 1'b1;
    chunk_end = count >= {1'b0, cfg.chunk_length};

    el_n   = (el_c != '1) ? el_c + 1'b1 : el_c;
    speech = pk > {1'b0, cfg.speech_threshold};
    seen_n = seen_c || speech;
    last_n = speech ? el_n : last_c;
    gap    = el_n - last_n;

    if (el_n >= cfg.max_chunks) begin
      cause = CAUSE_MAX_LEN;
    end else if (seen_n && gap > cfg.silence_chunks) begin
      cause = CAUSE_SILENCE;
    end else if (!seen_n && el_n > cfg.no_speech_chunks) begin
      cause = CAUSE_NO_SPEECH;
    end else begin
      cause = CAUSE_NONE;
    end

    sample_count_nxt = sc_c;
    running_peak_nxt = pk_c;
    elapsed_nxt      = el_c;
    last_speech_nxt  = last_c;
    seen_nxt         = seen_c;
    stopped_nxt      = stopped_c;
    if (active && !chunk_end) begin
      sample_count_nxt = count[CHUNK_LEN_W-1:0];
      running_peak_nxt = pk;
    end else if (active) begin
      sample_count_nxt = '0;
      running_peak_nxt = '0;
      elapsed_nxt      = el_n;
      last_speech_nxt  = last_n;
      seen_nxt         = seen_n;
      stopped_nxt      = (cause != CAUSE_NONE);
    end

    res_valid        = active && chunk_end;
    res.chunk_peak   = pk;
    res.heard_speech = seen_n;
    res.stop         = (cause != CAUSE_NONE);
    res.stop_cause   = cause;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_count_r <= '0;
      running_peak_r <= '0;
      elapsed_r      <= '0;
      last_speech_r  <= '0;
      seen_r         <= 1'b0;
      stopped_r      <= 1'b0;
    end else if (fire) begin
      sample_count_r <= sample_count_nxt;
      running_peak_r <= running_peak_nxt;
      elapsed_r      <= elapsed_nxt;
      last_speech_r  <= last_speech_nxt;
      seen_r         <= seen_nxt;
      stopped_r      <= stopped_nxt;
    end
  end

endmodule

// ===== hdl/speech_endpoint_detector.sv =====
// A result passes through two registers: the item that ends its chunk is held in the input
// register, and its result is then held in the output register until the sink takes it.
// Throughput: one item per cycle unless a finished result waits in the output register.
// Reset (rst_n, synchronous, active low) clears the session state and the valid flags of both
// pipeline registers and loads the configuration registers with their defaults.
module speech_endpoint_detector import sep_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  sep_in_if.sink            in_ch,
  sep_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  // The configuration block holds the five registers and serves reads of them.
  sep_cfg_t cfg;

  sep_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Input register. An accepted item waits here until it moves on into the core, which it does
  // whenever it yields no result, or the output register is free or being emptied.
  logic                       s1_valid_r, s1_valid_nxt;
  logic signed [SAMPLE_W-1:0] s1_sample_r;
  logic                       s1_first_r;
  logic                       s1_adv;
  logic                       in_fire;

  // Output register, which holds a finished result until the sink takes it.
  logic     out_valid_r, out_valid_nxt;
  sep_res_t out_res_r;
  logic     out_free;

  logic     core_res_valid;
  sep_res_t core_res;

  assign out_free     = !out_valid_r || out_ch.ready;
  assign s1_adv       = s1_valid_r && (!core_res_valid || out_free);
  assign in_ch.ready  = !s1_valid_r || s1_adv;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign s1_valid_nxt = in_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_sample_r <= in_ch.sample;
      s1_first_r  <= in_ch.first;
    end
  end

  // The core applies the first flag, tracks the chunk peak and counters, and makes the
  // stop decision. Its session state moves only when the held item advances.
  sep_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (s1_adv),
    .sample    (s1_sample_r),
    .first     (s1_first_r),
    .cfg       (cfg),
    .res_valid (core_res_valid),
    .res       (core_res)
  );

  always_comb begin
    if (s1_adv && core_res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && core_res_valid) begin
      out_res_r <= core_res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.chunk_peak   = out_res_r.chunk_peak;
  assign out_ch.heard_speech = out_res_r.heard_speech;
  assign out_ch.stop         = out_res_r.stop;
  assign out_ch.stop_cause   = out_res_r.stop_cause;

  // The stop flag agrees with the cause code on every result.
  a_stop_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_res_r.stop == (out_res_r.stop_cause != CAUSE_NONE)))
    else $error("stop flag disagrees with stop cause");

  // A silence stop needs speech heard, a no-speech stop needs none.
  a_cause_heard: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_res_r.stop_cause == CAUSE_SILENCE || out_res_r.stop_cause ==
      CAUSE_NO_SPEECH) |-> (out_res_r.heard_speech == (out_res_r.stop_cause == CAUSE_SILENCE)))
    else $error("stop cause inconsistent with heard flag");

  // A held item that cannot advance is neither lost nor overwritten.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_sample_r) && $stable(s1_first_r))
    else $error("input register lost a stalled item");

  // A pending result is never replaced before the sink takes it.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |-> !(s1_adv && core_res_valid))
    else $error("result overwritten while stalled");

endmodule

// ===== tb/tb_speech_endpoint_detector.sv =====
module tb_speech_endpoint_detector import sep_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // Cycles with no handshake on any port before the run is declared hung. The longest
  // legitimate quiet stretch is the deliberate receiver hold-off below, so this leaves
  // a wide margin.
  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int NUM_PHASES   = 12;
  localparam int PHASE_ITEMS  = 170;
  localparam int SHORT_ITEMS  = 60;
  // An accepted item passes through the input register and then the output register; the settle
  // wait covers both before touching the registers, so that nothing is still in flight.
  localparam int SETTLE_CYCLES = 4;

  // One row of the directed table. A row either writes a register or sends one item. Where
  // the outcome of an item is obvious it is typed into the row; otherwise the predictor
  // supplies it.
  typedef struct packed {
    logic                 is_cfg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic [31:0]          value;
    logic                 first;
    logic                 typed;
    logic                 has_res;
    sep_res_t             res;
  } dir_row_t;

  localparam sep_res_t NO_RES = '0;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  sep_in_if  in_if ();
  sep_out_if out_if ();

  speech_endpoint_detector DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_if),
    .out_ch  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // Predictor copy of the block: its registers and the session state of the recording.
  sep_cfg_t          det_cfg;
  logic [11:0]       seg_count;
  logic [PEAK_W-1:0] seg_peak;
  logic [CNT_W-1:0]  chunks_elapsed;
  logic [CNT_W-1:0]  last_voiced_chunk;
  logic              voiced;
  logic              session_stopped;

  // Chunk results that have been predicted but not yet seen on the output.
  sep_res_t pending_chunks[$];

  int  mismatches;
  int  samples_sent;
  int  samples_ignored;
  int  chunks_seen;
  int  settings_used;
  int  stops_max_len;
  int  stops_silence;
  int  stops_no_speech;
  int  quiet_cycles;
  bit  tx_gaps;
  bit  rx_gaps;
  bit  hold_request;

  // Directed items. The opening block runs with one sample per chunk, so every item ends a
  // chunk and the outcome can be worked out by hand: a recording that runs out of time with
  // no speech, one that reaches its maximum length, one that stops on silence after speech,
  // samples ignored after a stop, a new recording started in the middle of another, and the
  // full-scale values of both signs. Then a zero chunk length together with a zero maximum
  // (the very first chunk must stop), and finally a chunk length lowered while a chunk is
  // part-way through, which has to end that chunk at the next sample.
  dir_row_t directed_rows [30] = '{
    '{1'b1, REG_CHUNK_LENGTH,     32'd1,   1'b0, 1'b0, 1'b0, NO_RES},
    '{1'b1, REG_SPEECH_THRESHOLD, 32'd600, 1'b0, 1'b0, 1'b0, NO_RES},
    '{1'b1, REG_MAX_CHUNKS,       32'd4,   1'b0, 1'b0, 1'b0, NO_RES},
    '{1'b1, REG_SILENCE_CHUNKS,   32'd1,   1'b0, 1'b0, 1'b0, NO_RES},
    '{1'b1, REG_NO_SPEECH_CHUNKS, 32'd2,   1'b0, 1'b0, 1'b0, NO_RES},
    '{1'b0, '0, 0,      1'b1, 1'b1, 1'b1, '{16'd0,     1'b0, 1'b0, CAUSE_NONE}},
    '{1'b0, '0, 0,      1'b0, 1'b1, 1'b1, '{16'd0,     1'b0, 1'b0, CAUSE_NONE}},
    '{1'b0, '0, 0,      1'b0, 1'b1, 1'b1, '{16'd0,     1'b0, 1'b1, CAUSE_NO_SPEECH}},
    '{1'b0, '0, 32767,  1'b0, 1'b1, 1'b0, NO_RES},
    '{1'b0, '0, -32768, 1'b1, 1'b1, 1'b1, '{16'd32768, 1'b1, 1'b0, CAUSE_NONE}},
    '{1'b0, '0, 601,    1'b0, 1'b1, 1'b1, '{16'd601,   1'b1, 1'b0, CAUSE_NONE}},
    '{1'b0, '0, 600,    1'b0, 1'b1, 1'b1, '{16'd600,   1'b1, 1'b0, CAUSE_NONE}},
    '{1'b0, '0, -600,   1'b0, 1'b1, 1'b1, '{16'd600,   1'b1, 1'b1, CAUSE_MAX_LEN}},
    '{1'b0, '0, 5,      1'b0, 1'b1, 1'b0, NO_RES},
    '{1'b0, '0, 32767,  1'b1, 1'b1, 1'b1, '{16'd32767, 1'b1, 1'b0, CAUSE_NONE}},
    '{1'b0, '0, 1,      1'b0, 1'b1, 1'b1, '{16'd1,     1'b1, 1'b0, CAUSE_NONE}},
    '{1'b0, '0, -1,     1'b0, 1'b1, 1'b1, '{16'd1,     1'b1, 1'b1, CAUSE_SILENCE}},
    '{1'b0, '0, -32767, 1'b1, 1'b1, 1'b1, '{16'd32767, 1'b1, 1'b0, CAUSE_NONE}},
    '{1'b0, '0, 0,      1'b1, 1'b1, 1'b1, '{16'd0,     1'b0, 1'b0, CAUSE_NONE}},
    '{1'b1, REG_CHUNK_LENGTH,     32'd0,   1'b0, 1'b0, 1'b0, NO_RES},
    '{1'b1, REG_MAX_CHUNKS,       32'd0,   1'b0, 1'b0, 1'b0, NO_RES},
    '{1'b0, '0, 100,    1'b1, 1'b1, 1'b1, '{16'd100,   1'b0, 1'b1, CAUSE_MAX_LEN}},
    '{1'b0, '0, 7,      1'b0, 1'b1, 1'b0, NO_RES},
    '{1'b1, REG_CHUNK_LENGTH,     32'd4,   1'b0, 1'b0, 1'b0, NO_RES},
    '{1'b1, REG_MAX_CHUNKS,       32'd100, 1'b0, 1'b0, 1'b0, NO_RES},
    '{1'b0, '0, 10,     1'b1, 1'b0, 1'b0, NO_RES},
    '{1'b0, '0, 20,     1'b0, 1'b0, 1'b0, NO_RES},
    '{1'b0, '0, 30,     1'b0, 1'b0, 1'b0, NO_RES},
    '{1'b1, REG_CHUNK_LENGTH,     32'd2,   1'b0, 1'b0, 1'b0, NO_RES},
    '{1'b0, '0, -40,    1'b0, 1'b1, 1'b1, '{16'd40,    1'b0, 1'b0, CAUSE_NONE}}
  };

  // Every mismatch goes through here: one line, one count. Printing stops after a hundred
  // lines so that a badly broken block cannot flood the log, but the count goes on.
  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 100) begin
      $display("MISMATCH at time %0t: %s", $realtime, what);
    end
  endtask

  function automatic void clear_session();
    seg_count         = '0;
    seg_peak          = '0;
    chunks_elapsed    = '0;
    last_voiced_chunk = '0;
    voiced            = 1'b0;
    session_stopped   = 1'b0;
  endfunction

  // Advances the predicted session by one sample. Returns 1 with the chunk result when the
  // sample closes a chunk, and 0 when it is absorbed into the running chunk or ignored
  // because the recording has already stopped.
  function automatic bit endpoint_step(input logic signed [SAMPLE_W-1:0] s, input logic f,
                                       output sep_res_t r);
    int                 mag;
    logic [CAUSE_W-1:0] cause;
    r = '0;
    if (f) begin
      clear_session();
    end
    if (session_stopped) begin
      return 1'b0;
    end
    // The most negative sample gives 32768, which still fits the 16-bit peak.
    mag = (s < 0) ? -int'(s) : int'(s);
    if (mag > int'(seg_peak)) begin
      seg_peak = mag[PEAK_W-1:0];
    end
    // A chunk length of zero acts as one, and a count at or past a newly lowered length
    // ends the chunk straight away; the comparison covers both.
    if (int'(seg_count) + 1 < int'(det_cfg.chunk_length)) begin
      seg_count = seg_count + 1'b1;
      return 1'b0;
    end
    r.chunk_peak = seg_peak;
    seg_count    = '0;
    seg_peak     = '0;
    if (chunks_elapsed != '1) begin
      chunks_elapsed = chunks_elapsed + 1'b1;
    end
    if (int'(r.chunk_peak) > int'(det_cfg.speech_threshold)) begin
      voiced            = 1'b1;
      last_voiced_chunk = chunks_elapsed;
    end
    // The stop conditions are tried in a fixed order: length first, then silence after
    // speech, then no speech at all.
    if (chunks_elapsed >= det_cfg.max_chunks) begin
      cause = CAUSE_MAX_LEN;
    end else if (voiced && (chunks_elapsed - last_voiced_chunk) > det_cfg.silence_chunks) begin
      cause = CAUSE_SILENCE;
    end else if (!voiced && chunks_elapsed > det_cfg.no_speech_chunks) begin
      cause = CAUSE_NO_SPEECH;
    end else begin
      cause = CAUSE_NONE;
    end
    session_stopped = (cause != CAUSE_NONE);
    r.heard_speech  = voiced;
    r.stop          = session_stopped;
    r.stop_cause    = cause;
    return 1'b1;
  endfunction

  function automatic logic [DATA_W-1:0] reg_value(input logic [REG_IDX_W-1:0] idx);
    case (idx)
      REG_CHUNK_LENGTH:     return DATA_W'(det_cfg.chunk_length);
      REG_SPEECH_THRESHOLD: return DATA_W'(det_cfg.speech_threshold);
      REG_MAX_CHUNKS:       return DATA_W'(det_cfg.max_chunks);
      REG_SILENCE_CHUNKS:   return DATA_W'(det_cfg.silence_chunks);
      REG_NO_SPEECH_CHUNKS: return DATA_W'(det_cfg.no_speech_chunks);
      default:              return '0;
    endcase
  endfunction

  // Register write: setup cycle, then access cycle, then idle, so that a following
  // transfer never raises psel in the step where this one drops it.
  task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_CHUNK_LENGTH:     det_cfg.chunk_length     = value[CHUNK_LEN_W-1:0];
      REG_SPEECH_THRESHOLD: det_cfg.speech_threshold = value[THR_W-1:0];
      REG_MAX_CHUNKS:       det_cfg.max_chunks       = value[CNT_W-1:0];
      REG_SILENCE_CHUNKS:   det_cfg.silence_chunks   = value[CNT_W-1:0];
      REG_NO_SPEECH_CHUNKS: det_cfg.no_speech_chunks = value[CNT_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Reads every register back and compares it with the predictor's copy.
  task automatic check_registers();
    logic [DATA_W-1:0] got;
    for (int i = REG_CHUNK_LENGTH; i <= REG_NO_SPEECH_CHUNKS; i++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {i[REG_IDX_W-1:0], 2'b00};
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      got = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      if (got !== reg_value(i[REG_IDX_W-1:0])) begin
        report_mismatch($sformatf("register %0d reads %0h, expected %0h", i, got,
                                  reg_value(i[REG_IDX_W-1:0])));
      end
      @(posedge clk);
    end
  endtask

  // Offers one item and holds it until the block takes it. The valid stays high on return,
  // so that back-to-back items never drop it for a step; whoever comes next decides.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic f,
                             output bit got, output sep_res_t r);
    in_if.valid  <= 1'b1;
    in_if.sample <= s;
    in_if.first  <= f;
    do @(posedge clk); while (!in_if.ready);
    if (session_stopped && !f) begin
      samples_ignored++;
    end
    samples_sent++;
    got = endpoint_step(s, f, r);
  endtask

  task automatic sender_gap();
    in_if.valid <= 1'b0;
    repeat ($urandom_range(1, 9)) @(posedge clk);
  endtask

  // Brings the block to rest: no item offered, every predicted result received, and a few
  // more cycles for any item that was absorbed without a result to leave the pipeline.
  // The watchdog covers the case where an expected result never comes.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (pending_chunks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Each random phase gets its own register setting. The first two are fixed extremes: a
  // zero threshold with zero silence and no-speech limits and the largest maximum, and then
  // the longest chunk with the highest threshold, which leaves a chunk part-way through for
  // the next phase to cut short. The rest are mostly short chunks and low limits so that
  // recordings run through all their stop conditions often.
  task automatic program_phase(input int ph);
    int cl;
    int thr;
    int mx;
    int sil;
    int nsp;
    cl  = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 6) :
          ($urandom_range(0, 1) != 0) ? $urandom_range(0, 20) : $urandom_range(20, 64);
    thr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 3000);
    case ($urandom_range(0, 7))
      0:       mx = 0;
      1:       mx = 65535;
      default: mx = $urandom_range(1, 24);
    endcase
    sil = ($urandom_range(0, 7) == 0) ? 65535 : $urandom_range(0, 6);
    nsp = ($urandom_range(0, 7) == 0) ? 65535 : $urandom_range(0, 12);
    case (ph)
      0: begin
        cl = 1; thr = 0; mx = 65535; sil = 0; nsp = 0;
      end
      1: begin
        cl = 4095; thr = 32767; mx = 1; sil = 65535; nsp = 65535;
      end
      2: cl = 0;
      default: ;
    endcase
    cfg_write(REG_CHUNK_LENGTH, cl);
    cfg_write(REG_SPEECH_THRESHOLD, thr);
    cfg_write(REG_MAX_CHUNKS, mx);
    cfg_write(REG_SILENCE_CHUNKS, sil);
    cfg_write(REG_NO_SPEECH_CHUNKS, nsp);
    check_registers();
    settings_used++;
  endtask

  // Receiver. It normally takes every result, stalls in short random bursts while gaps are
  // enabled, and once on request holds off for a long stretch so that the block fills up
  // and has to stall its input.
  initial begin
    out_if.ready = 1'b1;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_if.ready <= 1'b1;
      end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_if.ready <= 1'b1;
      end
    end
  end

  // Result checker: every accepted result is matched against the oldest prediction.
  always @(posedge clk) begin
    sep_res_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      chunks_seen++;
      if (pending_chunks.size() == 0) begin
        report_mismatch($sformatf("unexpected result: peak %0d heard %0b stop %0b cause %0d",
                                  out_if.chunk_peak, out_if.heard_speech, out_if.stop,
                                  out_if.stop_cause));
      end else begin
        want = pending_chunks.pop_front();
        if (out_if.chunk_peak !== want.chunk_peak || out_if.heard_speech !== want.heard_speech ||
            out_if.stop !== want.stop || out_if.stop_cause !== want.stop_cause) begin
          report_mismatch($sformatf(
            "chunk %0d: got peak %0d heard %0b stop %0b cause %0d, want %0d %0b %0b %0d",
            chunks_seen, out_if.chunk_peak, out_if.heard_speech, out_if.stop,
            out_if.stop_cause, want.chunk_peak, want.heard_speech, want.stop,
            want.stop_cause));
        end
        case (want.stop_cause)
          CAUSE_MAX_LEN:   stops_max_len++;
          CAUSE_SILENCE:   stops_silence++;
          CAUSE_NO_SPEECH: stops_no_speech++;
          default: ;
        endcase
      end
    end
  end

  // Watchdog: any handshake on the item ports or a register transfer counts as progress.
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || psel) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no progress for %0d cycles, %0d results still awaited",
               STALL_LIMIT, pending_chunks.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    bit                         got;
    bit                         loud;
    bit                         skip;
    int                         done;
    int                         quota;
    int                         thr_i;
    int                         m;
    logic                       f;
    logic signed [SAMPLE_W-1:0] s;
    sep_res_t                   r;

    rst_n        = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_if.valid  = 1'b0;
    in_if.sample = '0;
    in_if.first  = 1'b0;
    hold_request = 1'b0;
    tx_gaps      = 1'b1;
    rx_gaps      = 1'b1;
    loud         = 1'b0;

    det_cfg.chunk_length     = CHUNK_LENGTH_RST;
    det_cfg.speech_threshold = SPEECH_THRESHOLD_RST;
    det_cfg.max_chunks       = MAX_CHUNKS_RST;
    det_cfg.silence_chunks   = SILENCE_CHUNKS_RST;
    det_cfg.no_speech_chunks = NO_SPEECH_CHUNKS_RST;
    clear_session();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The registers must come out of reset at their defaults.
    check_registers();

    // Directed part: walk the table. Typed outcomes are queued as written; the predictor
    // still steps on every item so that its session stays in line with the block.
    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        wait_drained();
        cfg_write(directed_rows[i].reg_idx, directed_rows[i].value);
      end else begin
        if (tx_gaps && $urandom_range(0, 7) == 0) begin
          sender_gap();
        end
        send_sample(directed_rows[i].value[SAMPLE_W-1:0], directed_rows[i].first, got, r);
        if (directed_rows[i].typed) begin
          if (directed_rows[i].has_res) begin
            pending_chunks.push_back(directed_rows[i].res);
          end
        end else if (got) begin
          pending_chunks.push_back(r);
        end
      end
    end
    wait_drained();
    check_registers();

    // Random part. Each phase is a run of recordings: a first-sample item opens one, its
    // samples drift between quiet and loud stretches relative to the threshold so that
    // speech, silence after speech and plain silence all occur, and once it has stopped a
    // few stray samples may follow before the next recording opens. Now and then a
    // recording is restarted part-way through. Ignored samples do not count towards the
    // phase quota.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drained();
      program_phase(ph);
      if (ph >= NUM_PHASES - 2) begin
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
      end else if (ph == 0) begin
        // One sample per chunk and a sender that never pauses, while the receiver holds
        // off: the block has to back up and refuse items.
        tx_gaps      = 1'b0;
        rx_gaps      = 1'b0;
        hold_request = 1'b1;
      end else begin
        tx_gaps = ($urandom_range(0, 3) != 0);
        rx_gaps = ($urandom_range(0, 3) != 0);
      end
      quota = (ph == 1) ? SHORT_ITEMS : PHASE_ITEMS;
      thr_i = int'(det_cfg.speech_threshold);
      done  = 0;
      while (done < quota) begin
        if (session_stopped) begin
          f = ($urandom_range(0, 3) != 0);
        end else begin
          f = ($urandom_range(0, 79) == 0);
        end
        skip = session_stopped && !f;
        if ($urandom_range(0, 5) == 0) begin
          loud = !loud;
        end
        case ($urandom_range(0, 9))
          0: s = SAMPLE_W'($urandom);
          1: begin
            case ($urandom_range(0, 3))
              0:       s = 16'sh8000;
              1:       s = 16'sh7FFF;
              2:       s = 16'sh0000;
              default: s = 16'shFFFF;
            endcase
          end
          default: begin
            m = loud ? $urandom_range(thr_i + 1, 32768) : $urandom_range(0, thr_i);
            s = (m == 32768 || $urandom_range(0, 1) != 0) ? SAMPLE_W'(-m) : SAMPLE_W'(m);
          end
        endcase
        if (tx_gaps && $urandom_range(0, 7) == 0) begin
          sender_gap();
        end
        send_sample(s, f, got, r);
        if (got) begin
          pending_chunks.push_back(r);
        end
        if (!skip) begin
          done++;
        end
      end
    end

    wait_drained();
    $display("Sent %0d samples (%0d ignored after a stop) under %0d random register settings,",
             samples_sent, samples_ignored, settings_used);
    $display("checked %0d chunk results; stops by length %0d, silence %0d, no speech %0d.",
             chunks_seen, stops_max_len, stops_silence, stops_no_speech);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/sep_pkg.sv
hdl/sep_if.sv
hdl/sep_regs.sv
hdl/sep_core.sv
hdl/speech_endpoint_detector.sv
tb/tb_speech_endpoint_detector.sv
